/* hdl/scma_pkg.sv */
// ----------------------------------------------------------------------------
// Segmented column max/argmax package
// Shared constants and functions for the column cell row and the top level.
// ----------------------------------------------------------------------------
package scma_pkg;

   localparam int unsigned ValueBits  = 32;
   localparam int unsigned ArgmaxBits = 24;
   localparam int unsigned CfgBits    = 7;

   function automatic logic is_nan(input logic [ValueBits-1:0] x);
      is_nan = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
   endfunction

   function automatic logic greater(input logic [ValueBits-1:0] a,
                                    input logic [ValueBits-1:0] b);
      logic [ValueBits-1:0] ka;
      logic [ValueBits-1:0] kb;
      ka = a[31] ? ~a : (a | 32'h8000_0000);
      kb = b[31] ? ~b : (b | 32'h8000_0000);
      if (is_nan(a) || is_nan(b)) begin
         greater = 1'b0;
      end else if (((a | b) & 32'h7FFF_FFFF) == 32'd0) begin
         greater = 1'b0;
      end else begin
         greater = ka > kb;
      end
   endfunction

endpackage

/* hdl/scma_cell.sv */
// ----------------------------------------------------------------------------
// Column cell
// Holds one column's running maximum and argmax. On advance it passes the
// transaction on to the next cell. When the transaction belongs to this
// cell's column, the cell updates its own state and replaces the element
// and row index it passes on with the column's new maximum and argmax.
// ----------------------------------------------------------------------------
module scma_cell #(
   parameter int unsigned ROW_INDEX_BITS = 24,
   parameter int unsigned COL_BITS       = 6,
   parameter int unsigned INDEX          = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              in_valid,
   input  logic [scma_pkg::ValueBits-1:0]    in_value,
   input  logic [COL_BITS-1:0]               in_col,
   input  logic [ROW_INDEX_BITS-1:0]         in_row,
   input  logic                              in_first,
   input  logic                              in_last_row,
   input  logic                              in_row_end,
   output logic                              out_valid,
   output logic [scma_pkg::ValueBits-1:0]    out_value,
   output logic [COL_BITS-1:0]               out_col,
   output logic [ROW_INDEX_BITS-1:0]         out_row,
   output logic                              out_first,
   output logic                              out_last_row,
   output logic                              out_row_end
);

   logic [scma_pkg::ValueBits-1:0] max_ff;
   logic [ROW_INDEX_BITS-1:0]      arg_ff;
   logic                           valid_ff;
   logic [scma_pkg::ValueBits-1:0] value_ff;
   logic [COL_BITS-1:0]            col_ff;
   logic [ROW_INDEX_BITS-1:0]      row_ff;
   logic                           first_ff;
   logic                           last_row_ff;
   logic                           row_end_ff;
   logic                           match;
   logic                           take_in;

   assign match   = in_valid && (in_col == COL_BITS'(INDEX));
   assign take_in = match && (in_first || scma_pkg::greater(in_value, max_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (take_in) begin
            max_ff <= in_value;
            arg_ff <= in_row;
         end
         value_ff    <= (match && !take_in) ? max_ff : in_value;
         row_ff      <= (match && !take_in) ? arg_ff : in_row;
         col_ff      <= in_col;
         first_ff    <= in_first;
         last_row_ff <= in_last_row;
         row_end_ff  <= in_row_end;
      end
   end

   assign out_valid    = valid_ff;
   assign out_value    = value_ff;
   assign out_col      = col_ff;
   assign out_row      = row_ff;
   assign out_first    = first_ff;
   assign out_last_row = last_row_ff;
   assign out_row_end  = row_end_ff;

endmodule

/* hdl/segmented_column_max_argmax_unit.sv */
// ----------------------------------------------------------------------------
// Segmented column max/argmax unit
// Elements enter a row of COLS_MAX column cells and, while the row advances,
// move one cell per cycle. The cell that owns the element's column compares
// and updates its running maximum and argmax as the transaction passes, so
// one element is accepted on every such cycle. An element flagged as the
// last row of its segment leaves the last cell as a result into the result
// register. While a presented result is not taken, the whole row of cells
// holds and input stalls; up to COLS_MAX + 1 transactions can be in flight.
// ----------------------------------------------------------------------------
module segmented_column_max_argmax_unit #(
   parameter int unsigned COLS_MAX       = 64,
   parameter int unsigned ROW_INDEX_BITS = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [scma_pkg::CfgBits-1:0]         csr_num_columns,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [scma_pkg::ValueBits-1:0]       req_value,
   input  logic                                 req_last_row_of_segment,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [scma_pkg::ValueBits-1:0]       rsp_max_value,
   output logic [scma_pkg::ArgmaxBits-1:0]      rsp_argmax_row,
   output logic                                 rsp_last_column
);

   localparam int unsigned ColBits = (COLS_MAX > 1) ? $clog2(COLS_MAX) : 1;
   localparam int unsigned CntBits = $clog2(COLS_MAX + 1) > scma_pkg::CfgBits
                                     ? $clog2(COLS_MAX + 1) : scma_pkg::CfgBits;

   logic [scma_pkg::CfgBits-1:0]  ncfg_ff;
   logic [ColBits-1:0]            col_ff;
   logic [ROW_INDEX_BITS-1:0]     row_ff;
   logic                          first_ff;
   logic                          rsp_valid_ff;
   logic [scma_pkg::ValueBits-1:0]  rsp_max_ff;
   logic [scma_pkg::ArgmaxBits-1:0] rsp_arg_ff;
   logic                          rsp_last_ff;

   logic [CntBits-1:0]            ncols;
   logic [CntBits-1:0]            col_ext;
   logic                          row_end;
   logic                          accept;
   logic                          advance;

   logic                           chain_valid    [COLS_MAX+1];
   logic [scma_pkg::ValueBits-1:0] chain_value    [COLS_MAX+1];
   logic [ColBits-1:0]             chain_col      [COLS_MAX+1];
   logic [ROW_INDEX_BITS-1:0]      chain_row      [COLS_MAX+1];
   logic                           chain_first    [COLS_MAX+1];
   logic                           chain_last_row [COLS_MAX+1];
   logic                           chain_row_end  [COLS_MAX+1];

   assign csr_ready = 1'b1;
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;

   always_comb begin
      ncols = CntBits'(ncfg_ff);
      if (ncols == '0) begin
         ncols = CntBits'(1);
      end else if (ncols > CntBits'(COLS_MAX)) begin
         ncols = CntBits'(COLS_MAX);
      end
   end

   assign col_ext = CntBits'(col_ff);
   assign row_end = (col_ext + CntBits'(1)) >= ncols;

   assign chain_valid[0]    = req_valid;
   assign chain_value[0]    = req_value;
   assign chain_col[0]      = col_ff;
   assign chain_row[0]      = row_ff;
   assign chain_first[0]    = first_ff;
   assign chain_last_row[0] = req_last_row_of_segment;
   assign chain_row_end[0]  = row_end;

   for (genvar g = 0; g < COLS_MAX; g++) begin : g_cell
      scma_cell #(
         .ROW_INDEX_BITS (ROW_INDEX_BITS),
         .COL_BITS       (ColBits),
         .INDEX          (g)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .advance      (advance),
         .in_valid     (chain_valid[g]),
         .in_value     (chain_value[g]),
         .in_col       (chain_col[g]),
         .in_row       (chain_row[g]),
         .in_first     (chain_first[g]),
         .in_last_row  (chain_last_row[g]),
         .in_row_end   (chain_row_end[g]),
         .out_valid    (chain_valid[g+1]),
         .out_value    (chain_value[g+1]),
         .out_col      (chain_col[g+1]),
         .out_row      (chain_row[g+1]),
         .out_first    (chain_first[g+1]),
         .out_last_row (chain_last_row[g+1]),
         .out_row_end  (chain_row_end[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ncfg_ff      <= scma_pkg::CfgBits'(1);
         col_ff       <= '0;
         row_ff       <= '0;
         first_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            ncfg_ff <= csr_num_columns;
         end
         if (advance) begin
            rsp_valid_ff <= chain_valid[COLS_MAX] && chain_last_row[COLS_MAX];
         end
         if (accept) begin
            if (row_end) begin
               col_ff   <= '0;
               first_ff <= req_last_row_of_segment;
               if (row_ff != '1) begin
                  row_ff <= row_ff + ROW_INDEX_BITS'(1);
               end
            end else begin
               col_ff <= col_ff + ColBits'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_max_ff  <= chain_value[COLS_MAX];
         rsp_arg_ff  <= scma_pkg::ArgmaxBits'(chain_row[COLS_MAX]);
         rsp_last_ff <= chain_row_end[COLS_MAX];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_max_value   = rsp_max_ff;
   assign rsp_argmax_row  = rsp_arg_ff;
   assign rsp_last_column = rsp_last_ff;

endmodule

/* test/scma_checker.sv */
// ----------------------------------------------------------------------------
// Segmented column max/argmax checker
// Watches the configuration, element and result channels of the unit. It
// keeps its own copy of the per-column maximum and argmax state, predicts
// the result of every accepted last-row-of-segment element, and compares
// each accepted result field by field with the oldest prediction waiting.
// ----------------------------------------------------------------------------
module scma_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [scma_pkg::CfgBits-1:0]         csr_num_columns,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [scma_pkg::ValueBits-1:0]       req_value,
   input  logic                                 req_last_row_of_segment,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [scma_pkg::ValueBits-1:0]       rsp_max_value,
   input  logic [scma_pkg::ArgmaxBits-1:0]      rsp_argmax_row,
   input  logic                                 rsp_last_column,
   output int                                   errors,
   output int                                   pending,
   output int                                   results
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned NumCols = 64;
   localparam logic [23:0] RowLimit = 24'hFF_FFFF;

   typedef struct packed {
      logic [31:0] max_value;
      logic [23:0] argmax_row;
      logic        last_column;
   } col_result_type;

   logic [31:0]       col_max [NumCols];
   logic [23:0]       col_arg [NumCols];
   logic [5:0]        col_pos;
   logic [23:0]       row_pos;
   logic              opening_row;
   logic [6:0]        width_reg;
   col_result_type    col_results_due [$];

   function automatic logic float_nan(input logic [31:0] x);
      return (x[30:23] == 8'hFF) && (x[22:0] != 0);
   endfunction

   function automatic logic float_above(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] oa;
      logic [31:0] ob;
      if (float_nan(a) || float_nan(b) || (a[30:0] == 0 && b[30:0] == 0)) begin
         return 1'b0;
      end
      oa = a[31] ? ~a : {1'b1, a[30:0]};
      ob = b[31] ? ~b : {1'b1, b[30:0]};
      return oa > ob;
   endfunction

   task automatic take_element(input logic [31:0] v, input logic flag);
      int             ncols;
      int             col;
      logic           row_end;
      col_result_type r;
      ncols = width_reg;
      if (ncols < 1) ncols = 1;
      if (ncols > NumCols) ncols = NumCols;
      col = col_pos;
      row_end = (col + 1 >= ncols);
      if (opening_row || float_above(v, col_max[col])) begin
         col_max[col] = v;
         col_arg[col] = row_pos;
      end
      if (flag) begin
         r.max_value   = col_max[col];
         r.argmax_row  = col_arg[col];
         r.last_column = row_end;
         col_results_due.push_back(r);
      end
      if (row_end) begin
         col_pos = 0;
         if (row_pos < RowLimit) row_pos = row_pos + 1;
         opening_row = flag;
      end else begin
         col_pos = col + 1;
      end
   endtask

   task automatic check_result();
      col_result_type e;
      if (col_results_due.size() == 0) begin
         $display("%0t: unexpected result max=%h arg=%0d last=%b", $time,
                  rsp_max_value, rsp_argmax_row, rsp_last_column);
         errors++;
         return;
      end
      e = col_results_due.pop_front();
      if (rsp_max_value !== e.max_value) begin
         $display("%0t: max_value expected %h actual %h", $time,
                  e.max_value, rsp_max_value);
         errors++;
      end
      if (rsp_argmax_row !== e.argmax_row) begin
         $display("%0t: argmax_row expected %0d actual %0d", $time,
                  e.argmax_row, rsp_argmax_row);
         errors++;
      end
      if (rsp_last_column !== e.last_column) begin
         $display("%0t: last_column expected %b actual %b", $time,
                  e.last_column, rsp_last_column);
         errors++;
      end
   endtask

   initial begin
      errors = 0;
      pending = 0;
      results = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumCols; i++) begin
            col_max[i] = '0;
            col_arg[i] = '0;
         end
         col_pos = 0;
         row_pos = 0;
         opening_row = 1'b1;
         width_reg = 7'd1;
         col_results_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_result();
            results++;
         end
         if (csr_valid && csr_ready) width_reg = csr_num_columns;
         if (req_valid && req_ready) take_element(req_value, req_last_row_of_segment);
      end
      pending = col_results_due.size();
   end

endmodule

/* test/tb_segmented_column_max_argmax_unit.sv */
// ----------------------------------------------------------------------------
// Segmented column max/argmax unit testbench
// Drives rows of single precision elements through the unit under several
// column counts, with directed ties, signed zeros, NaNs and infinities, then
// random rows and segments. A checker module predicts and compares results;
// this module makes stimulus, random idling and backpressure, and the verdict.
// ----------------------------------------------------------------------------
module tb_segmented_column_max_argmax_unit;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [6:0]  csr_num_columns;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_value;
   logic        req_last_row_of_segment;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_max_value;
   logic [23:0] rsp_argmax_row;
   logic        rsp_last_column;
   int          errors;
   int          pending;
   int          results;
   int          elements;
   logic        calm;
   logic        hold_off;

   segmented_column_max_argmax_unit uut (.*);

   scma_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // The result side stalls at random, and once holds off for a long stretch.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         rsp_ready <= calm || ($urandom_range(99) >= 28);
      end
   end

   function automatic logic [31:0] pick_value();
      case ($urandom_range(9))
         0: return $urandom_range(1) ? 32'h0000_0000 : 32'h8000_0000;
         1: return {$urandom_range(1) ? 1'b1 : 1'b0, 8'hFF, 23'h1 + 23'($urandom)};
         2: return $urandom_range(1) ? 32'h7F80_0000 : 32'hFF80_0000;
         3, 4: return {$urandom_range(1) ? 1'b1 : 1'b0, 8'h80, 21'd0, 2'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   task automatic send_element(input logic [31:0] v, input logic flag);
      if (!calm && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      req_last_row_of_segment <= flag;
      do @(posedge clock); while (!req_ready);
      elements++;
   endtask

   task automatic write_columns(input logic [6:0] n);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_num_columns <= n;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Rows of the given width; the phase ends on a segment end.
   task automatic send_rows(input int width, input int rows, input int flag_pct);
      logic flag;
      logic mixed;
      for (int r = 0; r < rows; r++) begin
         flag = (r == rows - 1) || ($urandom_range(99) < flag_pct);
         mixed = (r != rows - 1) && ($urandom_range(99) < 10);
         for (int c = 0; c < width; c++) begin
            send_element(pick_value(), mixed ? 1'($urandom) : flag);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_num_columns = '0;
      req_valid = 1'b0;
      req_value = '0;
      req_last_row_of_segment = 1'b0;
      calm = 1'b0;
      hold_off = 1'b0;
      elements = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: two columns, ties, signed zeros, leading NaN, infinities.
      write_columns(7'd2);
      send_element(32'h8000_0000, 1'b0);
      send_element(32'h7FC0_0000, 1'b0);
      send_element(32'h0000_0000, 1'b0);
      send_element(32'h3F80_0000, 1'b0);
      send_element(32'h3F80_0000, 1'b0);
      send_element(32'h7F80_0000, 1'b0);
      send_element(32'hFFFF_FFFF, 1'b1);
      send_element(32'h7F7F_FFFF, 1'b1);
      send_element(32'hFF80_0000, 1'b0);
      send_element(32'h0000_0001, 1'b0);
      send_element(32'h8000_0001, 1'b1);
      send_element(32'h0000_0000, 1'b1);
      send_element(32'h7F80_0000, 1'b1);
      send_element(32'hFF7F_FFFF, 1'b1);
      write_columns(7'd0);
      send_element(32'hFFFF_FFFF, 1'b1);
      send_element(32'h4000_0000, 1'b0);
      send_element(32'h4000_0000, 1'b1);
      write_columns(7'd127);
      send_rows(64, 1, 100);

      // Random rows under several widths.
      write_columns(7'd1);
      send_rows(1, 60, 25);
      write_columns(7'd3);
      send_rows(3, 30, 25);
      write_columns(7'd7);
      send_rows(7, 12, 30);
      // Width lowered mid-row: the next element closes the row.
      for (int i = 0; i < 5; i++) send_element(pick_value(), 1'b1);
      write_columns(7'd3);
      send_element(pick_value(), 1'b1);
      calm = 1'b1;
      write_columns(7'd64);
      hold_off = 1'b1;
      send_rows(64, 2, 100);
      calm = 1'b0;
      write_columns(7'($urandom_range(1, 16)));
      send_rows(16, 8, 30);
      write_columns(7'd5);
      send_rows(5, 20, 30);
      write_columns(7'($urandom_range(2, 6)));
      send_rows(6, 10, 40);
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Sent %0d elements over widths 1 to 64 and checked %0d column results.",
               elements, results);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* segmented_column_max_argmax_unit.f */
hdl/scma_pkg.sv
hdl/scma_cell.sv
hdl/segmented_column_max_argmax_unit.sv
test/scma_checker.sv
test/tb_segmented_column_max_argmax_unit.sv
